### src/lb64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lb64_pkg
// shared constants and types of the lenient base64 decoder
// ----------------------------------------------------------------------------
package lb64_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned AccW   = 12;
  localparam int unsigned PendW  = 3;
  localparam int unsigned TotalW = 4;

  // alphabet boundaries
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharW-1:0] CharDigit0 = 8'h30;
  localparam logic [CharW-1:0] CharDigit9 = 8'h39;
  localparam logic [CharW-1:0] CharPlus   = 8'h2B;
  localparam logic [CharW-1:0] CharSlash  = 8'h2F;
  localparam logic [CharW-1:0] CharPad    = 8'h3D;

  localparam logic [SextW-1:0] SextLowerBase = 6'd26;
  localparam logic [SextW-1:0] SextDigitBase = 6'd52;
  localparam logic [SextW-1:0] SextPlus      = 6'd62;
  localparam logic [SextW-1:0] SextSlash     = 6'd63;

  localparam logic [TotalW-1:0] BitsPerSextet = 4'd6;
  localparam logic [TotalW-1:0] BitsPerByte   = 4'd8;

  // sextet lookup result
  typedef struct packed {
    logic             valid;
    logic [SextW-1:0] value;
  } lb64_sext_t;

  // result of one step of the decoder
  typedef struct packed {
    logic             has_result;
    logic [CharW-1:0] out_byte;
    logic             byte_valid;
    logic             message_done;
  } lb64_res_t;

endpackage
`default_nettype wire

### src/lb64_char_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lb64_char_if
// character channel: one text byte and the end-of-message mark per request
// ----------------------------------------------------------------------------
interface lb64_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_message;

  modport source (output valid, output in_char, output end_of_message, input ready);
  modport sink   (input valid, input in_char, input end_of_message, output ready);
endinterface
`default_nettype wire

### src/lb64_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lb64_byte_if
// result channel: decoded byte with its valid and message-done marks
// ----------------------------------------------------------------------------
interface lb64_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       message_done;

  modport source (output valid, output out_byte, output byte_valid,
                  output message_done, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input message_done, output ready);
endinterface
`default_nettype wire

### src/lb64_sextet_dec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lb64_sextet_dec
// maps a character byte to its base64 sextet value
// ----------------------------------------------------------------------------
module lb64_sextet_dec (
  input  logic [7:0]          char_i,
  output lb64_pkg::lb64_sext_t sext_o
);
  import lb64_pkg::*;

  logic [SextW-1:0] off_upper;
  logic [SextW-1:0] off_lower;
  logic [SextW-1:0] off_digit;

  assign off_upper = SextW'(char_i - CharUpperA);
  assign off_lower = SextW'(char_i - CharLowerA);
  assign off_digit = SextW'(char_i - CharDigit0);

  always_comb begin
    sext_o = '0;
    if (char_i >= CharUpperA && char_i <= CharUpperZ) begin
      sext_o.valid = 1'b1;
      sext_o.value = off_upper;
    end else if (char_i >= CharLowerA && char_i <= CharLowerZ) begin
      sext_o.valid = 1'b1;
      sext_o.value = off_lower + SextLowerBase;
    end else if (char_i >= CharDigit0 && char_i <= CharDigit9) begin
      sext_o.valid = 1'b1;
      sext_o.value = off_digit + SextDigitBase;
    end else if (char_i == CharPlus) begin
      sext_o.valid = 1'b1;
      sext_o.value = SextPlus;
    end else if (char_i == CharSlash) begin
      sext_o.valid = 1'b1;
      sext_o.value = SextSlash;
    end
  end

endmodule
`default_nettype wire

### src/lb64_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lb64_core
// bit accumulator, pad tracking and byte extraction for one character
// ----------------------------------------------------------------------------
module lb64_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                eom_i,
  output lb64_pkg::lb64_res_t res_o
);
  import lb64_pkg::*;

  logic [AccW-1:0]   acc_q, acc_d;
  logic [PendW-1:0]  pend_q, pend_d;
  logic              stop_q, stop_d;

  lb64_sext_t        sext;
  logic              is_pad;
  logic              take;
  logic [AccW-1:0]   acc_new;
  logic [TotalW-1:0] total;
  logic              emit;
  logic [PendW-1:0]  shift;
  logic [CharW-1:0]  dec_byte;

  lb64_sextet_dec u_sext (
    .char_i (char_i),
    .sext_o (sext)
  );

  assign is_pad   = (char_i == CharPad);
  assign take     = !stop_q && !is_pad && sext.valid;
  assign acc_new  = {acc_q[AccW-SextW-1:0], sext.value};
  assign total    = TotalW'(pend_q) + BitsPerSextet;
  assign emit     = take && (total >= BitsPerByte);
  // total minus eight keeps the same low bits
  assign shift    = total[PendW-1:0];
  assign dec_byte = CharW'(acc_new >> shift);

  always_comb begin
    res_o.has_result   = emit || eom_i;
    res_o.out_byte     = emit ? dec_byte : '0;
    res_o.byte_valid   = emit;
    res_o.message_done = eom_i;
  end

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    stop_d = stop_q;
    if (step_i) begin
      if (eom_i) begin
        acc_d  = '0;
        pend_d = '0;
        stop_d = 1'b0;
      end else begin
        if (!stop_q && is_pad) stop_d = 1'b1;
        if (take) begin
          acc_d  = acc_new;
          pend_d = total[PendW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      stop_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      stop_q <= stop_d;
    end
  end

  a_pend_even : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[0] == 1'b0)
    else $error("pending bit count is odd");

  a_eom_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eom_i |=> pend_q == '0 && !stop_q && acc_q == '0)
    else $error("state not cleared after end of message");

  a_no_byte_after_pad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> !res_o.byte_valid)
    else $error("byte decoded after pad");

endmodule
`default_nettype wire

### src/lenient_base64_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lenient_base64_decoder
// streaming base64 decoder that skips non-alphabet bytes and stops at pad
// ----------------------------------------------------------------------------
// The block takes one base64 character per request and decodes one
// per clock unless the result side stalls: every input request is
// captured in an input register, decoded by short logic (alphabet
// lookup, 12-bit accumulator shift, byte select) and any result lands
// in an output register, so with both sides flowing a new character
// is accepted every cycle. Characters outside the alphabet
// (whitespace included) are dropped silently, the first '=' stops decoding
// until the end-of-message character, and leftover bits at the end are
// discarded. Characters that yield no byte produce no result request, while
// the end-of-message character always produces exactly one request with
// message_done set, after which all decoder state is back at reset.
// Backpressure on the result side stalls only characters that have a
// result to deliver; the output register lets the next character enter
// while a finished result still waits.
// ----------------------------------------------------------------------------
module lenient_base64_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  lb64_char_if.sink   in_i,
  lb64_byte_if.source out_o
);
  import lb64_pkg::*;

  // input register
  logic             s1_valid_q, s1_valid_d;
  logic [CharW-1:0] s1_char_q;
  logic             s1_eom_q;

  // output register
  logic             out_valid_q, out_valid_d;
  lb64_res_t        out_res_q;

  lb64_res_t        res;
  logic             out_free;
  logic             advance;
  logic             in_fire;

  lb64_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .char_i (s1_char_q),
    .eom_i  (s1_eom_q),
    .res_o  (res)
  );

  // output slot can take a result this cycle
  assign out_free = !out_valid_q || out_o.ready;
  // a character with no result never waits on the output side
  assign advance  = s1_valid_q && (!res.has_result || out_free);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= in_i.in_char;
      s1_eom_q  <= in_i.end_of_message;
    end
    if (advance && res.has_result) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_res_q.out_byte;
  assign out_o.byte_valid   = out_res_q.byte_valid;
  assign out_o.message_done = out_res_q.message_done;

  // every delivered result carries a byte or closes a message
  a_result_meaningful : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.byte_valid || out_res_q.message_done))
    else $error("empty result request");

  // a stalled character stays in the input register
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_char_q) && $stable(s1_eom_q))
    else $error("stalled character lost");

  // a result is never written over one that was not taken
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.has_result |-> out_free)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

### tb/sv/lb64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lb64_checker
// watches both channels of the base64 decoder, predicts every result from
// the accepted characters and compares the decoder output field by field
// ----------------------------------------------------------------------------
module lb64_checker
  import lb64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lb64_char_if        chr_mon,
  lb64_byte_if        res_mon,
  output int unsigned error_count_o,
  output int unsigned outstanding_o,
  output int unsigned chars_seen_o,
  output int unsigned bytes_seen_o,
  output int unsigned msgs_seen_o
);

  // predicted decoder state
  logic [AccW-1:0]  acc_q;
  logic [PendW-1:0] pend_q;
  logic             pad_seen_q;

  lb64_res_t expected_results [$];

  function automatic lb64_sext_t char_to_sextet(input logic [CharW-1:0] c);
    lb64_sext_t s;
    s.valid = 1'b1;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      s.value = SextW'(c - CharUpperA);
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      s.value = SextW'(c - CharLowerA) + SextLowerBase;
    end else if (c >= CharDigit0 && c <= CharDigit9) begin
      s.value = SextW'(c - CharDigit0) + SextDigitBase;
    end else if (c == CharPlus) begin
      s.value = SextPlus;
    end else if (c == CharSlash) begin
      s.value = SextSlash;
    end else begin
      s.valid = 1'b0;
      s.value = '0;
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lb64_res_t         got;
    lb64_res_t         want;
    lb64_res_t         pred;
    lb64_sext_t        sx;
    logic [TotalW-1:0] total;
    logic [CharW-1:0]  dec;
    logic              have;
    logic [AccW-1:0]   acc_n;
    logic [PendW-1:0]  pend_n;
    logic              pad_n;
    if (!rst_ni) begin
      acc_q         <= '0;
      pend_q        <= '0;
      pad_seen_q    <= 1'b0;
      expected_results.delete();
      error_count_o <= 0;
      outstanding_o <= 0;
      chars_seen_o  <= 0;
      bytes_seen_o  <= 0;
      msgs_seen_o   <= 0;
    end else begin
      // result side first: results trail their request by the input and output registers
      if (res_mon.valid && res_mon.ready) begin
        got = '{1'b1, res_mon.out_byte, res_mon.byte_valid, res_mon.message_done};
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: out_byte=%0h byte_valid=%0b message_done=%0b",
                 got.out_byte, got.byte_valid, got.message_done);
          error_count_o <= error_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %0h, actual %0h", want.out_byte, got.out_byte);
          end
          if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid mismatch: expected %0b, actual %0b",
                   want.byte_valid, got.byte_valid);
          end
          if (got.message_done !== want.message_done) begin
            $error("message_done mismatch: expected %0b, actual %0b",
                   want.message_done, got.message_done);
          end
          error_count_o <= error_count_o
                           + int'(got.out_byte !== want.out_byte)
                           + int'(got.byte_valid !== want.byte_valid)
                           + int'(got.message_done !== want.message_done);
        end
        bytes_seen_o <= bytes_seen_o + int'(got.byte_valid === 1'b1);
        msgs_seen_o  <= msgs_seen_o + int'(got.message_done === 1'b1);
      end

      if (chr_mon.valid && chr_mon.ready) begin
        have   = 1'b0;
        dec    = '0;
        acc_n  = acc_q;
        pend_n = pend_q;
        pad_n  = pad_seen_q;
        if (!pad_seen_q) begin
          if (chr_mon.in_char == CharPad) begin
            pad_n = 1'b1;
          end else begin
            sx = char_to_sextet(chr_mon.in_char);
            if (sx.valid) begin
              total = TotalW'(pend_q) + BitsPerSextet;
              // only the low half of the old accumulator survives the shift
              acc_n = {acc_q[AccW-SextW-1:0], sx.value};
              if (total >= BitsPerByte) begin
                total = total - BitsPerByte;
                dec   = CharW'(acc_n >> total);
                have  = 1'b1;
              end
              pend_n = total[PendW-1:0];
            end
          end
        end
        if (chr_mon.end_of_message) begin
          // the end mark always answers, then the state starts over
          pred = '{1'b1, dec, have, 1'b1};
          expected_results.insert(expected_results.size(), pred);
          acc_n  = '0;
          pend_n = '0;
          pad_n  = 1'b0;
        end else if (have) begin
          pred = '{1'b1, dec, 1'b1, 1'b0};
          expected_results.insert(expected_results.size(), pred);
        end
        acc_q        <= acc_n;
        pend_q       <= pend_n;
        pad_seen_q   <= pad_n;
        chars_seen_o <= chars_seen_o + 1;
      end

      outstanding_o <= expected_results.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the lenient base64 decoder
// ----------------------------------------------------------------------------
// A directed run of alphabet edges, whitespace, stray bytes and pad cases is
// followed by random traffic that is mostly encoded messages (with optional
// pad, sprinkled whitespace and some deliberately broken ones) mixed with
// bursts of raw noise. Four idling phases vary the sender gaps and the
// receiver stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import lb64_pkg::*;

  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharSpace = 8'h20;

  localparam int unsigned NumPhases    = 4;
  localparam int unsigned PhaseItems   = 185;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned TailCycles   = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  lb64_char_if chr ();
  lb64_byte_if res ();

  lenient_base64_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chr),
    .out_o  (res)
  );

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned chars_seen;
  int unsigned bytes_seen;
  int unsigned msgs_seen;

  lb64_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chr_mon       (chr),
    .res_mon       (res),
    .error_count_o (error_count),
    .outstanding_o (outstanding),
    .chars_seen_o  (chars_seen),
    .bytes_seen_o  (bytes_seen),
    .msgs_seen_o   (msgs_seen)
  );

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  // set by stimulus, picked up and counted down by the receiver process
  bit          hold_req      = 1'b0;
  int unsigned items_sent    = 0;

  // sextet value back to its alphabet character
  function automatic logic [CharW-1:0] sextet_to_char(input logic [SextW-1:0] v);
    if (v < SextLowerBase) return CharUpperA + CharW'(v);
    if (v < SextDigitBase) return CharLowerA + CharW'(v - SextLowerBase);
    if (v < SextPlus)      return CharDigit0 + CharW'(v - SextDigitBase);
    if (v == SextPlus)     return CharPlus;
    return CharSlash;
  endfunction

  function automatic logic [CharW-1:0] pick_whitespace();
    case ($urandom_range(3))
      0:       return CharCr;
      1:       return CharLf;
      2:       return CharSpace;
      default: return CharTab;
    endcase
  endfunction

  // one character request; valid stays high on exit so back-to-back
  // requests flow without a bubble
  task automatic send_char(input logic [CharW-1:0] c, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      chr.valid <= 1'b0;
      @(posedge clk_i);
    end
    chr.valid          <= 1'b1;
    chr.in_char        <= c;
    chr.end_of_message <= eom;
    do @(posedge clk_i); while (!chr.ready);
    items_sent++;
  endtask

  // pause the sender until every expected result has come back or the drain limit runs out
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    chr.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    // characters with no result may still sit in the pipe
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // random payload encoded to base64, sometimes damaged on purpose
  task automatic send_message();
    logic [CharW-1:0] text [$];
    logic [23:0]      grp;
    int unsigned      n, i, k, rem, kind, pos, ws_pct;
    bit               with_pad;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(0, 12);
    with_pad = ($urandom_range(3) != 0);
    for (i = 0; i < n; i += 3) begin
      rem = n - i;
      grp = {8'($urandom), 8'($urandom), 8'($urandom)};
      for (k = 0; k < 4; k++) begin
        if (k <= rem) begin
          text.insert(text.size(), sextet_to_char(grp[23-6*k -: 6]));
        end else if (with_pad) begin
          text.insert(text.size(), CharPad);
        end
      end
    end
    kind   = $urandom_range(9);
    ws_pct = 6;
    if (kind == 7) begin
      // heavy line breaking and blanks
      ws_pct = 35;
    end else if (kind == 8 && text.size() > 0) begin
      // pad in the middle, the tail must be ignored
      pos = $urandom_range(text.size() - 1);
      text.insert(pos, CharPad);
    end else if (kind == 9 && text.size() > 0) begin
      // lose a character, later bytes shift
      pos = $urandom_range(text.size() - 1);
      text.delete(pos);
    end
    if (text.size() == 0) text.insert(0, pick_whitespace());
    for (i = 0; i < text.size(); i++) begin
      if ($urandom_range(99) < ws_pct) send_char(pick_whitespace(), 1'b0);
      send_char(text[i], (i == text.size() - 1));
    end
  endtask

  // directed requests, {end_of_message, character}
  logic [8:0] directed [] = '{
    // alphabet edges, end mark on a byte-yielding character
    {1'b0, "A"}, {1'b0, "Z"}, {1'b0, "a"}, {1'b0, "z"},
    {1'b0, "0"}, {1'b0, "9"}, {1'b0, "+"}, {1'b1, "/"},
    // stray bytes and whitespace, then alphabet ignored after a pad
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CharCr}, {1'b0, CharLf},
    {1'b0, CharSpace}, {1'b0, CharTab}, {1'b0, "Q"}, {1'b0, "Q"},
    {1'b0, CharPad}, {1'b0, "A"}, {1'b1, "B"},
    // pad on the end request
    {1'b0, "Q"}, {1'b0, "Q"}, {1'b1, CharPad},
    // end mark on an alphabet character with no byte ready, and on a stray one
    {1'b1, "x"}, {1'b1, 8'h80}
  };

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned phase_end, p, j, burst;
    bit          hold_done;
    chr.valid          <= 1'b0;
    chr.in_char        <= '0;
    chr.end_of_message <= 1'b0;
    hold_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[d]) send_char(directed[d][7:0], directed[d][8]);
    drain_results();

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 55; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        // long receiver hold-off while the sender keeps pushing
        if (p == 0 && !hold_done && items_sent + 120 < phase_end) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(9) < 8) begin
          send_message();
        end else begin
          burst = $urandom_range(8, 1);
          for (j = 0; j < burst; j++) begin
            send_char(8'($urandom), ($urandom_range(19) == 0));
          end
        end
      end
      drain_results();
    end

    if (outstanding != 0) begin
      $error("%0d expected results never arrived", outstanding);
    end
    $display("checked %0d characters: %0d decoded bytes and %0d message ends",
             chars_seen, bytes_seen, msgs_seen);
    $display("over four idling phases with a long result-side hold-off");
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### lenient_base64_decoder.f
src/lb64_pkg.sv
src/lb64_char_if.sv
src/lb64_byte_if.sv
src/lb64_sextet_dec.sv
src/lb64_core.sv
src/lenient_base64_decoder.sv
tb/sv/lb64_checker.sv
tb/sv/tb_top.sv
